// ===== rtl/core/rgb_to_hsv_converter_unit_defines.svh =====
// Assertion shorthands for the RGB to HSV converter.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

	// Request and result payloads
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// Which channel holds the maximum
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// Constants, hue terms are doubled for half-up rounding
	localparam int unsigned HUE_FULL    = 360;
	localparam int unsigned HUE_SLOPE2  = 120;
	localparam int unsigned HUE2_GREEN  = 240;
	localparam int unsigned HUE2_BLUE   = 480;
	localparam int unsigned HUE2_WRAP   = 720;
	localparam int unsigned SAT_SCALE2  = 510;
	localparam int unsigned DIV_STEPS   = 9;

	// Extrema stage payload
	typedef struct packed {
		logic [7:0]        mx;
		logic [7:0]        delta;
		sector_t           sector;
		logic signed [8:0] diff;
	} ext_t;

	// Divider payload: two restoring dividers side by side
	typedef struct packed {
		logic [17:0] rem_h;
		logic [8:0]  den_h;
		logic [8:0]  quo_h;
		logic [16:0] rem_s;
		logic [8:0]  den_s;
		logic [8:0]  quo_s;
		logic        grey;
		logic        black;
		logic [7:0]  mx;
	} div_t;

endpackage
`default_nettype wire

// ===== rtl/core/rhc_prep.sv =====
`default_nettype none
module rhc_prep (
	input  wire logic         clk,
	input  wire logic         en_s1,
	input  wire logic         en_s2,
	input  wire rhc_pkg::pix_t pix,
	output rhc_pkg::div_t      div_s2
);

	rhc_pkg::ext_t ext_d;
	rhc_pkg::ext_t ext_s1;
	rhc_pkg::div_t div_d;

	// Find maximum, minimum and sector; red wins ties over green, green over blue
	always_comb begin
		logic [7:0] mn;
		logic [8:0] r9;
		logic [8:0] g9;
		logic [8:0] b9;
		r9 = {1'b0, pix.red};
		g9 = {1'b0, pix.green};
		b9 = {1'b0, pix.blue};
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			ext_d.mx     = pix.red;
			ext_d.sector = rhc_pkg::SECT_RED;
			ext_d.diff   = $signed(g9) - $signed(b9);
		end else if (pix.green >= pix.blue) begin
			ext_d.mx     = pix.green;
			ext_d.sector = rhc_pkg::SECT_GREEN;
			ext_d.diff   = $signed(b9) - $signed(r9);
		end else begin
			ext_d.mx     = pix.blue;
			ext_d.sector = rhc_pkg::SECT_BLUE;
			ext_d.diff   = $signed(r9) - $signed(g9);
		end
		mn = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		ext_d.delta = ext_d.mx - mn;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ext_s1 <= ext_d;
		end
	end

	// Build dividends and divisors: hue = (2n + delta) / (2 delta), sat likewise
	always_comb begin
		logic signed [19:0] diff_w;
		logic signed [19:0] delta_w;
		logic signed [19:0] base_w;
		logic signed [19:0] num_w;
		logic [9:0]         base2;
		case (ext_s1.sector)
			rhc_pkg::SECT_RED:   base2 = ext_s1.diff[8] ? 10'(rhc_pkg::HUE2_WRAP) : 10'd0;
			rhc_pkg::SECT_GREEN: base2 = 10'(rhc_pkg::HUE2_GREEN);
			rhc_pkg::SECT_BLUE:  base2 = 10'(rhc_pkg::HUE2_BLUE);
			default:             base2 = 10'd0;
		endcase
		diff_w  = 20'(ext_s1.diff);
		delta_w = $signed(20'(ext_s1.delta));
		base_w  = $signed(20'(base2));
		num_w   = diff_w * $signed(20'(rhc_pkg::HUE_SLOPE2)) + base_w * delta_w + delta_w;
		div_d.rem_h = num_w[17:0];
		div_d.den_h = {ext_s1.delta, 1'b0};
		div_d.quo_h = '0;
		div_d.rem_s = 17'(17'(ext_s1.delta) * 17'(rhc_pkg::SAT_SCALE2)) + 17'(ext_s1.mx);
		div_d.den_s = {ext_s1.mx, 1'b0};
		div_d.quo_s = '0;
		div_d.grey  = (ext_s1.delta == 8'd0);
		div_d.black = (ext_s1.mx == 8'd0);
		div_d.mx    = ext_s1.mx;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			div_s2 <= div_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rhc_div_stage.sv =====
`default_nettype none
module rhc_div_stage #(
	parameter int unsigned BIT = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire rhc_pkg::div_t div_in,
	output rhc_pkg::div_t      div_sn
);

	rhc_pkg::div_t div_d;

	// Resolve one quotient bit of each divider
	always_comb begin
		logic [17:0] trial_h;
		logic [16:0] trial_s;
		div_d   = div_in;
		trial_h = 18'({9'd0, div_in.den_h} << BIT);
		trial_s = 17'({8'd0, div_in.den_s} << BIT);
		if (div_in.rem_h >= trial_h) begin
			div_d.rem_h      = div_in.rem_h - trial_h;
			div_d.quo_h[BIT] = 1'b1;
		end
		if (div_in.rem_s >= trial_s) begin
			div_d.rem_s      = div_in.rem_s - trial_s;
			div_d.quo_s[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sn <= div_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rgb_to_hsv_converter_unit.sv =====
// Channel | Signals                        | Direction | Payload
// pixel   | pix_valid, pix_ready, pix      | in        | red, green, blue
// color   | hsv_valid, hsv_ready, hsv      | out       | hue, saturation, brightness
//
// Twelve register stages: extrema, dividend setup, nine restoring divide steps
// (one quotient bit each for hue and saturation), output fix-up.
// One pixel is accepted every cycle while the output drains.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// are squeezed out and a stalled output holds without loss.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none
`include "rgb_to_hsv_converter_unit_defines.svh"
module rgb_to_hsv_converter_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pix_valid,
	output logic               pix_ready,
	input  wire rhc_pkg::pix_t pix,
	output logic               hsv_valid,
	input  wire logic          hsv_ready,
	output rhc_pkg::hsv_t      hsv
);

	localparam int unsigned NSTG = rhc_pkg::DIV_STEPS + 3;

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   adv;
	rhc_pkg::div_t   div_pipe [rhc_pkg::DIV_STEPS+1];
	rhc_pkg::hsv_t   hsv_d;
	rhc_pkg::hsv_t   hsv_s12;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		adv[NSTG] = hsv_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign pix_ready = adv[0];

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= (k == 0) ? pix_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	rhc_prep u_prep (
		.clk    (clk),
		.en_s1  (adv[0]),
		.en_s2  (adv[1]),
		.pix    (pix),
		.div_s2 (div_pipe[0])
	);

	for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++) begin : g_div
		rhc_div_stage #(
			.BIT (rhc_pkg::DIV_STEPS - 1 - i)
		) u_div (
			.clk    (clk),
			.en     (adv[i+2]),
			.div_in (div_pipe[i]),
			.div_sn (div_pipe[i+1])
		);
	end

	// Wrap full circle, drop hue for grey and saturation for black
	always_comb begin
		rhc_pkg::div_t d;
		d = div_pipe[rhc_pkg::DIV_STEPS];
		if (d.grey || d.quo_h == 9'(rhc_pkg::HUE_FULL)) begin
			hsv_d.hue = '0;
		end else begin
			hsv_d.hue = d.quo_h;
		end
		hsv_d.saturation = d.black ? 8'd0 : d.quo_s[7:0];
		hsv_d.brightness = d.mx;
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			hsv_s12 <= hsv_d;
		end
	end

	assign hsv       = hsv_s12;
	assign hsv_valid = vld_q[NSTG-1];

	// Checks
	`RHC_ASSERT_IMPL(a_hue_range, hsv_valid, hsv.hue < 9'(rhc_pkg::HUE_FULL), "hue out of range")
	`RHC_ASSERT_IMPL(a_black, hsv_valid && hsv.brightness == 8'd0, hsv.saturation == 8'd0 && hsv.hue == 9'd0, "black pixel with color")
	`RHC_ASSERT_IMPL(a_full_stall, !pix_ready, (&vld_q) && !hsv_ready, "input stalled with room in pipe")
	`RHC_ASSERT_NEXT(a_enter, pix_valid && pix_ready, vld_q[0], "accepted request not in first stage")

endmodule
`default_nettype wire

// ===== bench/tb_rgb_to_hsv_converter_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_to_hsv_converter_unit;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int PIPE_DEPTH    = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DEG_SECTOR    = 60;
	localparam int DEG_GREEN     = 120;
	localparam int DEG_BLUE      = 240;
	localparam int DEG_CIRCLE    = 360;
	localparam int SAT_FULL      = 255;

	logic           clk;
	logic           arst_n;
	logic           pix_valid;
	logic           pix_ready;
	rhc_pkg::pix_t  pix;
	logic           hsv_valid;
	logic           hsv_ready;
	rhc_pkg::hsv_t  hsv;

	rhc_pkg::hsv_t  pending_hsv[$];
	int    err_count;
	int    cycle_count;
	int    send_idle_pct;
	int    recv_stall_pct;
	bit    hold_request;

	rgb_to_hsv_converter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv)
	);

	// Free-running clock
	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Compute the HSV form of one pixel in exact integer arithmetic
	function automatic rhc_pkg::hsv_t hsv_of_pixel(input rhc_pkg::pix_t p);
		int               r;
		int               g;
		int               b;
		int               hi;
		int               lo;
		int               span;
		int               num;
		int               h;
		int               s;
		rhc_pkg::sector_t sect;
		rhc_pkg::hsv_t    res;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		lo = r;
		sect = rhc_pkg::SECT_RED;
		if (g > hi) begin
			hi = g;
			sect = rhc_pkg::SECT_GREEN;
		end
		if (b > hi) begin
			hi = b;
			sect = rhc_pkg::SECT_BLUE;
		end
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		s = 0;
		if (hi != 0) s = (2 * SAT_FULL * span + hi) / (2 * hi);
		h = 0;
		if (span != 0) begin
			case (sect)
				rhc_pkg::SECT_RED: begin
					num = DEG_SECTOR * (g - b);
					if (num < 0) num += DEG_CIRCLE * span;
				end
				rhc_pkg::SECT_GREEN: num = DEG_SECTOR * (b - r) + DEG_GREEN * span;
				default:             num = DEG_SECTOR * (r - g) + DEG_BLUE * span;
			endcase
			h = (2 * num + span) / (2 * span);
			if (h >= DEG_CIRCLE) h -= DEG_CIRCLE;
		end
		res.hue        = h[8:0];
		res.saturation = s[7:0];
		res.brightness = hi[7:0];
		return res;
	endfunction

	// Pick a random pixel, biased toward ties, greys and extreme channels
	function automatic rhc_pkg::pix_t rand_pixel();
		rhc_pkg::pix_t p;
		int            mode;
		mode = $urandom_range(99);
		p = rhc_pkg::pix_t'(24'($urandom));
		if (mode < 15) begin
			case ($urandom_range(2))
				0: p.green = p.red;
				1: p.blue = p.green;
				default: p.blue = p.red;
			endcase
		end else if (mode < 25) begin
			p.green = p.red;
			p.blue = p.red;
		end else if (mode < 40) begin
			p.red   = $urandom_range(1) ? 8'hff - 8'($urandom_range(2)) : 8'($urandom_range(2));
			p.green = $urandom_range(1) ? 8'hff - 8'($urandom_range(2)) : 8'($urandom_range(2));
			p.blue  = $urandom_range(1) ? 8'hff - 8'($urandom_range(2)) : 8'($urandom_range(2));
		end
		return p;
	endfunction

	// Offer one request, idle at random first, return at the accepting edge
	task automatic send_pixel(input rhc_pkg::pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			pix       <= rhc_pkg::pix_t'(24'($urandom));
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(negedge clk); while (!pix_ready);
		pending_hsv.push_back(hsv_of_pixel(p));
		@(posedge clk);
	endtask

	// Drop valid and hold until every expected result has come out
	task automatic drain_results();
		pix_valid <= 1'b0;
		while (pending_hsv.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_pixel(rand_pixel());
		drain_results();
	endtask

	// Blacks, whites, greys, primaries, tied maxima and the hue wrap
	task automatic test_corner_pixels();
		rhc_pkg::pix_t corner[$];
		corner = '{
			'{8'd0,   8'd0,   8'd0},
			'{8'd255, 8'd255, 8'd255},
			'{8'd128, 8'd128, 8'd128},
			'{8'd1,   8'd1,   8'd1},
			'{8'd255, 8'd0,   8'd0},
			'{8'd0,   8'd255, 8'd0},
			'{8'd0,   8'd0,   8'd255},
			'{8'd255, 8'd255, 8'd0},
			'{8'd0,   8'd255, 8'd255},
			'{8'd255, 8'd0,   8'd255},
			'{8'd255, 8'd0,   8'd1},
			'{8'd255, 8'd1,   8'd0},
			'{8'd1,   8'd0,   8'd0},
			'{8'd1,   8'd0,   8'd1},
			'{8'd0,   8'd1,   8'd1},
			'{8'd2,   8'd1,   8'd0},
			'{8'd254, 8'd255, 8'd0},
			'{8'd0,   8'd254, 8'd255},
			'{8'd255, 8'd254, 8'd254},
			'{8'd170, 8'd85,  8'd0},
			'{8'd100, 8'd200, 8'd150}
		};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (corner[i]) send_pixel(corner[i]);
		drain_results();
	endtask

	task automatic test_streaming();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(200);
	endtask

	task automatic test_sparse_input();
		send_idle_pct  = 85;
		recv_stall_pct = 0;
		run_random(150);
	endtask

	task automatic test_output_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 85;
		run_random(150);
	endtask

	task automatic test_light_jitter();
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		run_random(250);
	endtask

	// Hold the output off long enough that the pipeline fills and stalls input
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		run_random(40);
	endtask

	// Receiver: random stalls, or one long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hsv_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result leaving the block with the oldest expectation
	always @(negedge clk) begin
		rhc_pkg::hsv_t want;
		if (arst_n && hsv_valid && hsv_ready) begin
			if (pending_hsv.size() == 0) begin
				$error("unexpected result: hue %0d sat %0d val %0d",
					hsv.hue, hsv.saturation, hsv.brightness);
				err_count++;
			end else begin
				want = pending_hsv.pop_front();
				if (hsv.hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hsv.hue);
					err_count++;
				end
				if (hsv.saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d",
						want.saturation, hsv.saturation);
					err_count++;
				end
				if (hsv.brightness !== want.brightness) begin
					$error("brightness: expected %0d, got %0d",
						want.brightness, hsv.brightness);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		pix_valid      = 1'b0;
		pix            = '0;
		hsv_ready      = 1'b0;
		err_count      = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_streaming();
		test_sparse_input();
		test_output_stall();
		test_backpressure();
		test_light_jitter();

		// Let the pipeline settle, then report
		drain_results();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (pending_hsv.size() != 0) begin
			$error("%0d expected results never arrived", pending_hsv.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
